FILE: sv/hsl_pkg.sv
package hsl_pkg;

   // Hue unit codes
   typedef enum logic [1:0] {
      UNIT_DEGREES  = 2'd0,
      UNIT_RADIANS  = 2'd1,
      UNIT_GRADIANS = 2'd2,
      UNIT_TURNS    = 2'd3
   } hue_unit_type;

   // Datapath widths
   localparam int HUE_W  = 20;   // hue position, steps of 1/2560 degree
   localparam int PCT_W  = 15;   // clamped percent, 0..25600
   localparam int PQ_W   = 30;   // p and q, scaled by 25600^2
   localparam int TSEL_W = 18;   // distance along a ramp, at most one sixth turn
   localparam int TERM_W = 47;   // one term of a channel numerator
   localparam int NUM_W  = 48;   // full channel numerator with rounding
   localparam int OUT_W  = 16;   // result field width
   localparam int REM_W  = 18;   // remainder check after the reciprocal estimate

   typedef logic [HUE_W-1:0]  hue_pos_type;
   typedef logic [PCT_W-1:0]  pct_type;
   typedef logic [PQ_W-1:0]   level_type;
   typedef logic [TERM_W-1:0] term_type;

   // Hue positions in steps of 1/2560 degree
   localparam hue_pos_type HUE_TURN       = 20'd921600;
   localparam hue_pos_type HUE_THIRD      = 20'd307200;
   localparam hue_pos_type HUE_SIXTH      = 20'd153600;
   localparam hue_pos_type HUE_HALF       = 20'd460800;
   localparam hue_pos_type HUE_TWO_THIRDS = 20'd614400;

   // Percent scale, Q7.8
   localparam pct_type PCT_FULL = 15'd25600;
   localparam pct_type PCT_HALF = 15'd12800;

   // Hue scale factors per unit, in 2^-16 steps of 1/2560 degree
   localparam logic [28:0] MULT_DEG  = 29'd655360;
   localparam logic [28:0] MULT_RAD  = 29'd37549362;
   localparam logic [28:0] MULT_GRAD = 29'd589824;
   localparam logic [28:0] MULT_TURN = 29'd235929600;

   // Whole-turn reduction: offset by a multiple of 3600, then divide by 16 * 225
   localparam logic [29:0] HUE_BIAS   = 30'd144000000;
   localparam logic [24:0] HUE_RECIP  = 25'd19088743;   // floor(2^32 / 225)
   localparam logic [7:0]  HUE_DIGITS = 8'd225;

   // Channel scaling: divide by 46875 * 2^(31 - frac bits)
   localparam logic [15:0] DIV_BASE        = 16'd46875;
   localparam logic [27:0] DIV_RECIP       = 28'd187649984; // floor(2^43 / 46875)
   localparam int          DIV_RECIP_SHIFT = 28;
   localparam int          DIV_DROP        = 15;

   // Opacity numerators on the channel scale
   localparam term_type ALPHA_ONE_NUM   = 47'd100663296000000;
   localparam term_type ALPHA_PCT_MULT  = 47'd3932160000;
   localparam term_type ALPHA_FRAC_MULT = 47'd393216000000;

endpackage

FILE: sv/hsl_hue.sv
module hsl_hue
   import hsl_pkg::*;
(
   input  logic               clock,
   input  logic [2:0]         stage_en,
   input  logic signed [23:0] hue_value,
   input  logic [1:0]         hue_unit,
   output hue_pos_type        hue_steps
);

   logic [28:0]        scale;
   logic signed [52:0] turn_prod_in, turn_prod_ff;
   logic signed [28:0] turns_whole;
   logic [29:0]        biased;
   logic [25:0]        digits;
   logic [50:0]        est_full;
   logic [18:0]        est_in, est_ff;
   logic [8:0]         digit_lo_in, digit_lo_ff;
   logic [3:0]         nibble_in, nibble_ff;
   logic [8:0]         frac_in, frac_ff;
   logic [18:0]        est_scaled;
   logic [8:0]         rem_raw;
   logic [7:0]         rem;
   hue_pos_type        steps_sum, hue_in, hue_ff;

   // Pick the unit scale
   always_comb begin
      case (hue_unit_type'(hue_unit))
         UNIT_DEGREES:  scale = MULT_DEG;
         UNIT_RADIANS:  scale = MULT_RAD;
         UNIT_GRADIANS: scale = MULT_GRAD;
         UNIT_TURNS:    scale = MULT_TURN;
         default:       scale = MULT_DEG;
      endcase
   end

   // Stage 1: scale the hue into 2^-16 steps
   assign turn_prod_in = hue_value * $signed({1'b0, scale});

   // Stage 2: estimate the quotient by 3600 whole steps of 2^24
   assign turns_whole = turn_prod_ff[52:24];
   assign biased      = {turns_whole[28], turns_whole} + HUE_BIAS;
   assign digits      = biased[29:4];
   assign est_full    = 51'(digits) * 51'(HUE_RECIP);
   assign est_in      = est_full[50:32];
   assign digit_lo_in = digits[8:0];
   assign nibble_in   = biased[3:0];
   assign frac_in     = turn_prod_ff[23:15];

   // Stage 3: correct the remainder, round to whole steps, wrap a full turn
   assign est_scaled = est_ff * 19'(HUE_DIGITS);
   assign rem_raw    = digit_lo_ff - est_scaled[8:0];
   assign rem        = (rem_raw >= 9'(HUE_DIGITS)) ? 8'(rem_raw - 9'(HUE_DIGITS))
                                                   : rem_raw[7:0];
   assign steps_sum  = {rem, nibble_ff, frac_ff[8:1]} + HUE_W'(frac_ff[0]);
   assign hue_in     = (steps_sum == HUE_TURN) ? '0 : steps_sum;

   // Advance each stage when its slot moves
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         turn_prod_ff <= turn_prod_in;
      end
      if (stage_en[1]) begin
         est_ff      <= est_in;
         digit_lo_ff <= digit_lo_in;
         nibble_ff   <= nibble_in;
         frac_ff     <= frac_in;
      end
      if (stage_en[2]) begin
         hue_ff <= hue_in;
      end
   end

   assign hue_steps = hue_ff;

endmodule

FILE: sv/hsl_ramp.sv
module hsl_ramp
   import hsl_pkg::*;
(
   input  logic        clock,
   input  logic        advance,
   input  hue_pos_type hue_pos,
   input  level_type   level_hi,
   input  level_type   level_lo,
   input  level_type   level_diff,
   output term_type    base_term,
   output term_type    slope_term
);

   logic [TSEL_W-1:0] tsel;
   level_type         level;
   logic [NUM_W-1:0]  slope_full;
   term_type          base_in, base_ff;
   term_type          slope_in, slope_ff;

   // Select the segment of the hue ramp
   always_comb begin
      tsel  = '0;
      level = level_lo;
      if (hue_pos < HUE_SIXTH) begin
         tsel = TSEL_W'(hue_pos);
      end else if (hue_pos < HUE_HALF) begin
         level = level_hi;
      end else if (hue_pos < HUE_TWO_THIRDS) begin
         tsel = TSEL_W'(HUE_TWO_THIRDS - hue_pos);
      end
   end

   // Form both numerator terms
   assign slope_full = NUM_W'(level_diff) * NUM_W'(tsel);
   assign slope_in   = TERM_W'(slope_full);
   assign base_in    = TERM_W'(level) * TERM_W'(HUE_SIXTH);

   always_ff @(posedge clock) begin
      if (advance) begin
         base_ff  <= base_in;
         slope_ff <= slope_in;
      end
   end

   assign base_term  = base_ff;
   assign slope_term = slope_ff;

endmodule

FILE: sv/hsl_div.sv
module hsl_div
   import hsl_pkg::*;
#(
   parameter int OUT_FRAC_BITS = 15
) (
   input  logic             clock,
   input  logic [2:0]       stage_en,
   input  term_type         base_term,
   input  term_type         slope_term,
   output logic [OUT_W-1:0] result
);

   localparam int SHIFT    = 31 - OUT_FRAC_BITS;
   localparam int SCALED_W = NUM_W - SHIFT;
   localparam int EST_W    = SCALED_W - DIV_DROP;
   localparam int PROD_W   = EST_W + DIV_RECIP_SHIFT;
   localparam logic [NUM_W-1:0] HALF_DIV = NUM_W'(DIV_BASE) << (SHIFT - 1);
   localparam logic [EST_W:0]   OUT_ONE  = (EST_W + 1)'(1) << OUT_FRAC_BITS;

   logic [NUM_W-1:0]    num_sum;
   logic [SCALED_W-1:0] scaled_in, scaled_ff;
   logic [PROD_W-1:0]   est_full;
   logic [EST_W-1:0]    est_in, est_ff;
   logic [REM_W-1:0]    low_in, low_ff;
   logic [REM_W-1:0]    est_low, est_scaled, rem;
   logic                bump;
   logic [EST_W:0]      quot;
   logic [OUT_W-1:0]    result_in, result_ff;

   // Stage A: add the rounding half and drop the power-of-two part
   assign num_sum   = NUM_W'(base_term) + NUM_W'(slope_term) + HALF_DIV;
   assign scaled_in = num_sum[NUM_W-1:SHIFT];

   // Stage B: reciprocal estimate, low by at most one
   assign est_full = PROD_W'(scaled_ff[SCALED_W-1:DIV_DROP]) * PROD_W'(DIV_RECIP);
   assign est_in   = est_full[PROD_W-1:DIV_RECIP_SHIFT];
   assign low_in   = scaled_ff[REM_W-1:0];

   // Stage C: check the remainder, bump the quotient, clamp to one
   assign est_low    = REM_W'(est_ff);
   assign est_scaled = est_low * REM_W'(DIV_BASE);
   assign rem        = low_ff - est_scaled;
   assign bump       = (rem >= REM_W'(DIV_BASE));
   assign quot       = {1'b0, est_ff} + (EST_W + 1)'(bump);
   assign result_in  = OUT_W'((quot > OUT_ONE) ? OUT_ONE : quot);

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         scaled_ff <= scaled_in;
      end
      if (stage_en[1]) begin
         est_ff <= est_in;
         low_ff <= low_in;
      end
      if (stage_en[2]) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

FILE: sv/hsl_to_rgb_converter_unit.sv
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  hue_value, hue_unit, saturation_pct,
//                                           lightness_pct, alpha_value,
//                                           alpha_is_percent, alpha_present
// rsp       out        rsp_valid/rsp_stall  red, green, blue, opacity
//
// One request per clock while rsp_stall does not hold the pipeline.
// The depth is set by the hue reduction (3 stages) and the constant
// divider on each channel (3 stages), with one stage each for the hue
// offsets and the ramp; p and q are formed alongside the hue reduction.
// Reset clears only the stage valid bits.
// A stall freezes only the stages that hold a request; empty stages keep
// filling, so requests are taken while a finished result waits.
module hsl_to_rgb_converter_unit
   import hsl_pkg::*;
#(
   parameter int OUT_FRAC_BITS = 15
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [23:0] req_hue_value,
   input  logic [1:0]         req_hue_unit,
   input  logic signed [15:0] req_saturation_pct,
   input  logic signed [15:0] req_lightness_pct,
   input  logic signed [15:0] req_alpha_value,
   input  logic               req_alpha_is_percent,
   input  logic               req_alpha_present,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_red,
   output logic [15:0]        rsp_green,
   output logic [15:0]        rsp_blue,
   output logic [15:0]        rsp_opacity
);

   localparam int STAGES = 8;
   localparam int ALPHA_DELAY = 5;
   localparam logic [8:0]  ALPHA_FRAC_ONE = 9'd256;
   localparam logic [16:0] OUT_ONE = 17'(1) << OUT_FRAC_BITS;

   function automatic pct_type clamp_pct(input logic signed [15:0] v);
      pct_type r;
      if (v < 0) begin
         r = '0;
      end else if (v > $signed({1'b0, PCT_FULL})) begin
         r = PCT_FULL;
      end else begin
         r = v[PCT_W-1:0];
      end
      return r;
   endfunction

   logic [STAGES:1] valid_in, valid_ff;
   logic [STAGES:1] stage_en;

   pct_type     sat1_in, sat1_ff, light1_in, light1_ff;
   pct_type     sat2_ff, light2_ff;
   logic [29:0] ls2_in, ls2_ff;
   logic [31:0] l_scaled, s_scaled, ls_wide, q_wide, p2_wide;
   logic        light_low;
   level_type   q3_in, q3_ff, p2_3_in, p2_3_ff;
   level_type   q4_ff, p2_4_ff, d4_in, d4_ff;

   pct_type     alpha_pct;
   logic [8:0]  alpha_frac;
   term_type    alpha_num_in;
   term_type    alpha_num_ff [1:ALPHA_DELAY];

   hue_pos_type hue3;
   logic [HUE_W:0] red_sum;
   hue_pos_type red_pos_in, red_pos_ff, hue4_ff, blue_pos_in, blue_pos_ff;

   term_type    red_base, red_slope, green_base, green_slope, blue_base, blue_slope;

   // Stage control: a stage moves when it is empty or the next one moves
   always_comb begin
      stage_en[STAGES] = !valid_ff[STAGES] || !rsp_stall;
      for (int k = STAGES - 1; k >= 1; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k + 1];
      end
      valid_in[1] = stage_en[1] ? req_valid : valid_ff[1];
      for (int k = 2; k <= STAGES; k++) begin
         valid_in[k] = stage_en[k] ? valid_ff[k - 1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !stage_en[1];
   assign rsp_valid = valid_ff[STAGES];

   // Stage 1: clamp percents, build the opacity numerator
   assign sat1_in    = clamp_pct(req_saturation_pct);
   assign light1_in  = clamp_pct(req_lightness_pct);
   assign alpha_pct  = clamp_pct(req_alpha_value);

   always_comb begin
      if (req_alpha_value < 0) begin
         alpha_frac = '0;
      end else if (req_alpha_value > $signed({7'd0, ALPHA_FRAC_ONE})) begin
         alpha_frac = ALPHA_FRAC_ONE;
      end else begin
         alpha_frac = req_alpha_value[8:0];
      end
      if (!req_alpha_present) begin
         alpha_num_in = ALPHA_ONE_NUM;
      end else if (req_alpha_is_percent) begin
         alpha_num_in = TERM_W'(alpha_pct) * ALPHA_PCT_MULT;
      end else begin
         alpha_num_in = TERM_W'(alpha_frac) * ALPHA_FRAC_MULT;
      end
   end

   // Stages 1 to 3: hue reduction
   hsl_hue u_hue (
      .clock     (clock),
      .stage_en  (stage_en[3:1]),
      .hue_value (req_hue_value),
      .hue_unit  (req_hue_unit),
      .hue_steps (hue3)
   );

   // Stage 2: lightness times saturation
   assign ls2_in = 30'(sat1_ff) * 30'(light1_ff);

   // Stage 3: q and p, both as exact integers over 25600^2
   always_comb begin
      l_scaled  = 32'(light2_ff) * 32'(PCT_FULL);
      s_scaled  = 32'(sat2_ff) * 32'(PCT_FULL);
      ls_wide   = 32'(ls2_ff);
      light_low = (light2_ff < PCT_HALF);
      if (light_low) begin
         q_wide  = l_scaled + ls_wide;
         p2_wide = l_scaled - ls_wide;
      end else begin
         q_wide  = l_scaled + s_scaled - ls_wide;
         p2_wide = l_scaled - s_scaled + ls_wide;
      end
      q3_in   = PQ_W'(q_wide);
      p2_3_in = PQ_W'(p2_wide);
   end

   // Stage 4: offset the hue by a third each way, take the ramp slope
   assign red_sum     = {1'b0, hue3} + {1'b0, HUE_THIRD};
   assign red_pos_in  = (red_sum >= {1'b0, HUE_TURN}) ? HUE_W'(red_sum - {1'b0, HUE_TURN})
                                                      : HUE_W'(red_sum);
   assign blue_pos_in = (hue3 >= HUE_THIRD) ? (hue3 - HUE_THIRD)
                                            : (hue3 + (HUE_TURN - HUE_THIRD));
   assign d4_in       = q3_ff - p2_3_ff;

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         sat1_ff   <= sat1_in;
         light1_ff <= light1_in;
      end
      if (stage_en[2]) begin
         sat2_ff   <= sat1_ff;
         light2_ff <= light1_ff;
         ls2_ff    <= ls2_in;
      end
      if (stage_en[3]) begin
         q3_ff   <= q3_in;
         p2_3_ff <= p2_3_in;
      end
      if (stage_en[4]) begin
         q4_ff       <= q3_ff;
         p2_4_ff     <= p2_3_ff;
         d4_ff       <= d4_in;
         red_pos_ff  <= red_pos_in;
         hue4_ff     <= hue3;
         blue_pos_ff <= blue_pos_in;
      end
   end

   // Carry the opacity numerator alongside the channel work
   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         alpha_num_ff[1] <= alpha_num_in;
      end
      for (int k = 2; k <= ALPHA_DELAY; k++) begin
         if (stage_en[k]) begin
            alpha_num_ff[k] <= alpha_num_ff[k - 1];
         end
      end
   end

   // Stage 5: ramp numerators per channel
   hsl_ramp u_ramp_red (
      .clock      (clock),
      .advance    (stage_en[5]),
      .hue_pos    (red_pos_ff),
      .level_hi   (q4_ff),
      .level_lo   (p2_4_ff),
      .level_diff (d4_ff),
      .base_term  (red_base),
      .slope_term (red_slope)
   );

   hsl_ramp u_ramp_green (
      .clock      (clock),
      .advance    (stage_en[5]),
      .hue_pos    (hue4_ff),
      .level_hi   (q4_ff),
      .level_lo   (p2_4_ff),
      .level_diff (d4_ff),
      .base_term  (green_base),
      .slope_term (green_slope)
   );

   hsl_ramp u_ramp_blue (
      .clock      (clock),
      .advance    (stage_en[5]),
      .hue_pos    (blue_pos_ff),
      .level_hi   (q4_ff),
      .level_lo   (p2_4_ff),
      .level_diff (d4_ff),
      .base_term  (blue_base),
      .slope_term (blue_slope)
   );

   // Stages 6 to 8: scale each numerator to the output format
   hsl_div #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_div_red (
      .clock      (clock),
      .stage_en   (stage_en[8:6]),
      .base_term  (red_base),
      .slope_term (red_slope),
      .result     (rsp_red)
   );

   hsl_div #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_div_green (
      .clock      (clock),
      .stage_en   (stage_en[8:6]),
      .base_term  (green_base),
      .slope_term (green_slope),
      .result     (rsp_green)
   );

   hsl_div #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_div_blue (
      .clock      (clock),
      .stage_en   (stage_en[8:6]),
      .base_term  (blue_base),
      .slope_term (blue_slope),
      .result     (rsp_blue)
   );

   hsl_div #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_div_alpha (
      .clock      (clock),
      .stage_en   (stage_en[8:6]),
      .base_term  (alpha_num_ff[ALPHA_DELAY]),
      .slope_term ('0),
      .result     (rsp_opacity)
   );

   // The reduced hue stays inside one turn
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] |-> hue3 < HUE_TURN)
      else $error("hue position outside one turn");

   // q never falls below p, so the ramp slope cannot wrap
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[4] |-> q4_ff >= p2_4_ff)
      else $error("q below p");

   // A full pipeline under an output stall takes no request
   assert property (@(posedge clock) disable iff (reset)
      (&valid_ff && rsp_stall) |-> req_stall)
      else $error("request taken into a full stalled pipeline");

   // Results never exceed one when OUT_FRAC_BITS is at most 15
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (OUT_FRAC_BITS > 15) ||
                    (rsp_red <= OUT_ONE && rsp_green <= OUT_ONE &&
                     rsp_blue <= OUT_ONE && rsp_opacity <= OUT_ONE))
      else $error("result above one");

endmodule
